### sv/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, register map, reset values and the tanh table builder for
// the position servo sigmoid drive.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int POS_W     = 24;
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = POS_W + FRAC_W;
  localparam int RATE_W    = 24;
  localparam int EL_W      = 16;
  localparam int GAIN_W    = 16;
  localparam int PWM_W     = 8;
  localparam int TBL_W     = 16;
  // table depth must be a power of two
  localparam int TBL_DEPTH = 1024;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);

  localparam int NEAR_LIMIT = 250;

  localparam int NUM_REGS = 6;
  localparam int PADDR_W  = $clog2(4 * NUM_REGS);
  localparam int PDATA_W  = 32;
  localparam int RIDX_W   = PADDR_W - 2;

  localparam logic [RIDX_W-1:0] REG_TARGET  = RIDX_W'(0);
  localparam logic [RIDX_W-1:0] REG_RATE    = RIDX_W'(1);
  localparam logic [RIDX_W-1:0] REG_MODE    = RIDX_W'(2);
  localparam logic [RIDX_W-1:0] REG_MAXDRV  = RIDX_W'(3);
  localparam logic [RIDX_W-1:0] REG_REVERSE = RIDX_W'(4);
  localparam logic [RIDX_W-1:0] REG_GAIN    = RIDX_W'(5);

  localparam logic [POS_W-1:0]  TARGET_RST = '0;
  localparam logic [RATE_W-1:0] RATE_RST   = RATE_W'(393);
  localparam logic [PWM_W-1:0]  MAXDRV_RST = PWM_W'(230);
  localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(1330);

  localparam logic [63:0] TANH_STEP = (64'd1 << 34) / TBL_DEPTH;

  typedef struct packed {
    logic [POS_W-1:0]  target_count;
    logic [RATE_W-1:0] ramp_rate;
    logic              run_mode;
    logic [PWM_W-1:0]  max_drive;
    logic              reverse_sense;
    logic [GAIN_W-1:0] sigmoid_log_gain;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic rnd;
    logic setp;
    logic err;
    logic xmul;
    logic idx;
    logic fin;
    logic clr;
  } dp_cmd_t;

  typedef logic [TBL_W-1:0] tanh_rom_t [TBL_DEPTH];

  // shift-subtract divide, elaboration use only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // tanh(x/2) in Q16 over |x| in [0,16); e tracks exp(-x) in Q30
  function automatic tanh_rom_t build_tanh_rom();
    tanh_rom_t   tbl;
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] e;
    one = 64'd1 << 30;
    t   = one;
    r   = one;
    e   = one;
    for (int k = 1; k <= 6; k++) begin
      t = udiv64((t * TANH_STEP) >> 30, 64'(k));
      if (k % 2 == 1) begin
        r = r - t;
      end else begin
        r = r + t;
      end
    end
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tbl[i] = TBL_W'(udiv64((one - e) << 16, one + e));
      e      = (e * r + (64'd1 << 29)) >> 30;
    end
    return tbl;
  endfunction

endpackage

### sv/position_servo_sigmoid_drive_unit.sv
// ----------------------------------------------------------------------------
// position_servo_sigmoid_drive_unit
// Position servo: ramped setpoint, logistic drive law, direction and PWM out.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   func, position, elapsed_us
//  out      out_valid / out_ready direction, pwm_level, at_target, near_target
//  cfg      APB psel/penable      paddr, pwdata, prdata (6 regs at 4*i)
//
//  A control tick steps through multiply, accumulate, round, setpoint, error,
//  gain multiply, table index and finish; a clear item goes to its clear step.
//  One item is in work at a time. The sequence has one multiplier per step and
//  a registered 1024-entry tanh ROM read. A full output register stalls the
//  last step. Synchronous reset clears setpoint, accumulators and direction.
// ----------------------------------------------------------------------------
module position_servo_sigmoid_drive_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [psd_pkg::POS_W-1:0]  position,
  input  logic [psd_pkg::EL_W-1:0]          elapsed_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              direction,
  output logic [psd_pkg::PWM_W-1:0]         pwm_level,
  output logic                              at_target,
  output logic                              near_target,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [psd_pkg::PADDR_W-1:0]       paddr,
  input  logic [psd_pkg::PDATA_W-1:0]       pwdata,
  output logic [psd_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import psd_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;

  psd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  psd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  psd_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .position    (position),
    .elapsed_us  (elapsed_us),
    .direction   (direction),
    .pwm_level   (pwm_level),
    .at_target   (at_target),
    .near_target (near_target)
  );

endmodule

### sv/psd_regs.sv
// ----------------------------------------------------------------------------
// psd_regs
// APB register file holding the servo configuration.
// ----------------------------------------------------------------------------
module psd_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psd_pkg::PADDR_W-1:0]  paddr,
  input  logic [psd_pkg::PDATA_W-1:0]  pwdata,
  output logic [psd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output psd_pkg::cfg_t                cfg
);
  import psd_pkg::*;

  logic              wr;
  logic [RIDX_W-1:0] ridx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign ridx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_count     <= TARGET_RST;
      cfg.ramp_rate        <= RATE_RST;
      cfg.run_mode         <= 1'b0;
      cfg.max_drive        <= MAXDRV_RST;
      cfg.reverse_sense    <= 1'b0;
      cfg.sigmoid_log_gain <= GAIN_RST;
    end else if (wr) begin
      case (ridx)
        REG_TARGET:  cfg.target_count     <= pwdata[POS_W-1:0];
        REG_RATE:    cfg.ramp_rate        <= pwdata[RATE_W-1:0];
        REG_MODE:    cfg.run_mode         <= pwdata[0];
        REG_MAXDRV:  cfg.max_drive        <= pwdata[PWM_W-1:0];
        REG_REVERSE: cfg.reverse_sense    <= pwdata[0];
        REG_GAIN:    cfg.sigmoid_log_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_TARGET:  prdata = PDATA_W'(cfg.target_count);
      REG_RATE:    prdata = PDATA_W'(cfg.ramp_rate);
      REG_MODE:    prdata = PDATA_W'(cfg.run_mode);
      REG_MAXDRV:  prdata = PDATA_W'(cfg.max_drive);
      REG_REVERSE: prdata = PDATA_W'(cfg.reverse_sense);
      REG_GAIN:    prdata = PDATA_W'(cfg.sigmoid_log_gain);
      default:     prdata = '0;
    endcase
  end

endmodule

### sv/psd_ctrl.sv
// ----------------------------------------------------------------------------
// psd_ctrl
// Sequencer for one tick: issues datapath commands and owns the handshakes.
// ----------------------------------------------------------------------------
module psd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             func,
  output logic             out_valid,
  input  logic             out_ready,
  output psd_pkg::dp_cmd_t cmd
);
  import psd_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_ACC  = 4'd2;
  localparam logic [3:0] S_RND  = 4'd3;
  localparam logic [3:0] S_SETP = 4'd4;
  localparam logic [3:0] S_ERR  = 4'd5;
  localparam logic [3:0] S_XMUL = 4'd6;
  localparam logic [3:0] S_IDX  = 4'd7;
  localparam logic [3:0] S_MAG  = 4'd8;
  localparam logic [3:0] S_CLR  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;

  assign out_free = ~out_valid | out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = func ? S_CLR : S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd    = 1'b1;
        state_next = S_SETP;
      end
      S_SETP: begin
        cmd.setp   = 1'b1;
        state_next = S_ERR;
      end
      S_ERR: begin
        cmd.err    = 1'b1;
        state_next = S_XMUL;
      end
      S_XMUL: begin
        cmd.xmul   = 1'b1;
        state_next = S_IDX;
      end
      S_IDX: begin
        cmd.idx    = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        if (out_free) begin
          cmd.clr    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin | cmd.clr) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/psd_dpath.sv
// ----------------------------------------------------------------------------
// psd_dpath
// Setpoint ramp, rounding, error, logistic drive lookup and result register.
// ----------------------------------------------------------------------------
module psd_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  psd_pkg::cfg_t                     cfg,
  input  psd_pkg::dp_cmd_t                  cmd,
  input  logic signed [psd_pkg::POS_W-1:0]  position,
  input  logic [psd_pkg::EL_W-1:0]          elapsed_us,
  output logic                              direction,
  output logic [psd_pkg::PWM_W-1:0]         pwm_level,
  output logic                              at_target,
  output logic                              near_target
);
  import psd_pkg::*;

  localparam int PROD_W    = RATE_W + EL_W + 2;
  localparam int X_W       = GAIN_W + POS_W + 3;
  localparam int IDX_SHIFT = FRAC_W + 4 - TBL_AW;

  localparam tanh_rom_t TANH_ROM = build_tanh_rom();

  localparam logic signed [POS_W-1:0] MAX_POS = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] MIN_POS = {1'b1, {(POS_W-1){1'b0}}};
  localparam logic [ACC_W:0] RND_HALF  = (ACC_W+1)'(1) << (FRAC_W - 1);
  localparam logic [ACC_W:0] RND_HALF1 = RND_HALF + (ACC_W+1)'(1);
  localparam logic signed [POS_W+1:0] ERR_ONE = (POS_W+2)'(1);
  localparam logic signed [POS_W:0] NEAR_LIM = (POS_W+1)'(NEAR_LIMIT);

  // latched item
  logic signed [POS_W-1:0] pos_q;
  logic [EL_W-1:0]         el_q;

  // servo state
  logic signed [ACC_W-1:0] move_acc;
  logic signed [ACC_W-1:0] spin_acc;
  logic signed [POS_W-1:0] setpoint;
  logic                    dir_reg;

  // pipeline registers
  logic signed [ACC_W-1:0] prod_q;
  logic                    lt_q;
  logic                    gt_q;
  logic                    upd_q;
  logic                    at_q;
  logic                    neg_q;
  logic [POS_W-1:0]        qmag_q;
  logic                    near_q;
  logic signed [POS_W+1:0] errp1_q;
  logic signed [X_W-1:0]   x_q;
  logic [TBL_W-1:0]        rom_q;
  logic                    sat_q;
  logic                    xpos_q;

  // ramp step
  logic signed [RATE_W-1:0] rate_s;
  logic signed [RATE_W:0]   rate_x;
  logic                     rate_neg;
  logic signed [RATE_W:0]   rate_op;
  logic signed [EL_W:0]     el_op;
  logic signed [PROD_W-1:0] prod;
  logic signed [POS_W-1:0]  tgt_s;
  logic signed [POS_W-1:0]  tgt_eff;
  logic                     lt;
  logic                     gt;

  assign rate_s   = $signed(cfg.ramp_rate);
  assign rate_x   = (RATE_W+1)'(rate_s);
  assign rate_neg = cfg.run_mode ? cfg.reverse_sense : rate_s[RATE_W-1];
  assign rate_op  = rate_neg ? -rate_x : rate_x;
  assign el_op    = $signed({1'b0, el_q});
  assign prod     = rate_op * el_op;

  assign tgt_s   = $signed(cfg.target_count);
  assign tgt_eff = !cfg.reverse_sense ? tgt_s :
                   (tgt_s == MIN_POS) ? MAX_POS : -tgt_s;
  assign lt      = setpoint < tgt_eff;
  assign gt      = setpoint > tgt_eff;

  // round half away from zero: -acc + half == ~acc + half + 1
  logic signed [ACC_W-1:0] acc_sel;
  logic                    acc_neg;
  logic [ACC_W:0]          rnd_sum;

  assign acc_sel = cfg.run_mode ? spin_acc : move_acc;
  assign acc_neg = acc_sel[ACC_W-1];
  assign rnd_sum = {1'b0, (acc_neg ? ~acc_sel : acc_sel)} + (acc_neg ? RND_HALF1 : RND_HALF);

  // error
  logic signed [POS_W:0]   err;
  logic signed [POS_W+1:0] errp1;

  assign err   = (POS_W+1)'(pos_q) - (POS_W+1)'(setpoint);
  assign errp1 = (POS_W+2)'(pos_q) - (POS_W+2)'(setpoint) + ERR_ONE;

  // drive law
  logic signed [GAIN_W:0] gain_x;
  logic [X_W-1:0]         ux;
  logic [X_W-1:0]         idx_full;

  assign gain_x   = $signed({1'b0, cfg.sigmoid_log_gain});
  assign ux       = x_q[X_W-1] ? X_W'(-x_q) : X_W'(x_q);
  assign idx_full = ux >> IDX_SHIFT;

  logic [PWM_W+TBL_W-1:0] mag_prod;
  logic [PWM_W-1:0]       mag;
  logic                   dir_next;

  assign mag_prod = cfg.max_drive * rom_q;
  assign mag      = sat_q ? cfg.max_drive : mag_prod[TBL_W +: PWM_W];
  assign dir_next = (mag != '0) ? xpos_q : dir_reg;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_q <= position;
      el_q  <= elapsed_us;
    end
    if (cmd.mul) begin
      prod_q <= ACC_W'(prod);
      lt_q   <= lt;
      gt_q   <= gt;
      upd_q  <= cfg.run_mode | lt | gt;
      at_q   <= ~cfg.run_mode & ~lt & ~gt;
    end
    if (cmd.rnd) begin
      neg_q  <= acc_neg;
      qmag_q <= rnd_sum[FRAC_W +: POS_W];
    end
    if (cmd.err) begin
      near_q  <= err <= NEAR_LIM;
      errp1_q <= errp1;
    end
    if (cmd.xmul) begin
      x_q <= gain_x * errp1_q;
    end
    if (cmd.idx) begin
      rom_q  <= TANH_ROM[idx_full[TBL_AW-1:0]];
      sat_q  <= |idx_full[X_W-1:TBL_AW];
      xpos_q <= ~x_q[X_W-1] & (x_q != '0);
    end
    if (cmd.fin) begin
      direction   <= dir_next;
      pwm_level   <= mag;
      at_target   <= at_q;
      near_target <= near_q;
    end else if (cmd.clr) begin
      direction   <= dir_reg;
      pwm_level   <= '0;
      at_target   <= 1'b0;
      near_target <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      move_acc <= '0;
      spin_acc <= '0;
      setpoint <= '0;
      dir_reg  <= 1'b0;
    end else if (cmd.clr) begin
      move_acc <= '0;
      spin_acc <= '0;
      setpoint <= '0;
    end else begin
      if (cmd.acc) begin
        if (cfg.run_mode) begin
          spin_acc <= spin_acc + prod_q;
        end else if (lt_q) begin
          move_acc <= move_acc + prod_q;
        end else if (gt_q) begin
          move_acc <= move_acc - prod_q;
        end
      end
      if (cmd.setp && upd_q) begin
        setpoint <= neg_q ? -$signed(qmag_q) : $signed(qmag_q);
      end
      if (cmd.fin) begin
        dir_reg <= dir_next;
      end
    end
  end

endmodule

### sv/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for the servo drive unit, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      func,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      direction,
  input logic [psd_pkg::PWM_W-1:0] pwm_level,
  input logic                      at_target,
  input logic                      near_target
);
  import psd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({direction, pwm_level, at_target, near_target}))
    else $error("result changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer taken while busy");

  // clear item, taken with the output free, answers with a zero drive
  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func && (!out_valid || out_ready) |-> ##2
      (out_valid && pwm_level == '0 && !at_target && !near_target))
    else $error("clear item result wrong or late");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind position_servo_sigmoid_drive_unit psd_checker u_psd_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the position servo sigmoid drive unit. Control
// ticks and clear items are driven through a queue with random idle bursts
// on both channels. Every tick is predicted by an in-bench servo model
// (ramped setpoint, logistic drive table, direction and PWM split), and the
// results are compared field by field. Registers are rewritten over the APB
// port between phases, extremes included.
// ----------------------------------------------------------------------------
module testbench;
  import psd_pkg::*;

  localparam int     CYCLE_LIMIT = 500000;
  localparam int     PHASES      = 10;
  localparam int     PHASE_TICKS = 135;
  localparam longint MAXPOS      = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint HALF        = longint'(1) << (FRAC_W - 1);

  typedef struct {
    logic              func;
    logic              rel;
    int                offset;
    logic [POS_W-1:0]  position;
    logic [EL_W-1:0]   elapsed;
    logic              drain;
  } tick_req_t;

  typedef struct {
    logic             direction;
    logic [PWM_W-1:0] pwm_level;
    logic             at_target;
    logic             near_target;
  } drive_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     func = 1'b0;
  logic signed [POS_W-1:0]  position = '0;
  logic [EL_W-1:0]          elapsed_us = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     direction;
  logic [PWM_W-1:0]         pwm_level;
  logic                     at_target;
  logic                     near_target;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  // servo model state and register copies
  logic signed [POS_W-1:0]  cfg_target = TARGET_RST;
  logic signed [RATE_W-1:0] cfg_rate = RATE_RST;
  logic                     cfg_mode = 1'b0;
  logic [PWM_W-1:0]         cfg_max = MAXDRV_RST;
  logic                     cfg_reverse = 1'b0;
  logic [GAIN_W-1:0]        cfg_gain = GAIN_RST;
  longint                   mv_acc = 0;
  longint                   sp_acc = 0;
  logic signed [POS_W-1:0]  sp_model = '0;
  logic                     dir_model = 1'b0;
  longint unsigned          tanh_q16 [TBL_DEPTH];

  tick_req_t  tick_queue [$];
  drive_t     drive_expected [$];
  tick_req_t  tx_req;
  int         ticks_queued = 0;
  int         ticks_accepted = 0;
  int         mismatches = 0;
  int         cycles = 0;
  int         tx_gap = 0;
  int         rx_stall = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         calm = 1'b0;
  bit         rx_hold_req = 1'b0;
  logic       in_done = 1'b0;

  position_servo_sigmoid_drive_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .position(position), .elapsed_us(elapsed_us),
    .out_valid(out_valid), .out_ready(out_ready),
    .direction(direction), .pwm_level(pwm_level),
    .at_target(at_target), .near_target(near_target),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // tanh(x/2) in Q16, exp(-step) by a six-term series in Q30
  function automatic void build_tanh_q16();
    longint unsigned one, stepv, term, rq, e;
    one = 64'd1 << 30;
    stepv = (64'd1 << 34) / TBL_DEPTH;
    term = one;
    rq = one;
    e = one;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * stepv) >> 30) / longint'(k);
      if (k % 2 == 1) begin
        rq = rq - term;
      end else begin
        rq = rq + term;
      end
    end
    for (int i = 0; i < TBL_DEPTH; i++) begin
      tanh_q16[i] = ((one - e) << 16) / (one + e);
      e = (e * rq + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic longint wrap_acc(input longint v);
    logic signed [ACC_W-1:0] w;
    w = v[ACC_W-1:0];
    return longint'(w);
  endfunction

  // nearest integer, halves away from zero, wrapped to the position width
  function automatic logic signed [POS_W-1:0] round_setpoint(input longint acc);
    longint q;
    if (acc >= 0) begin
      q = (acc + HALF) >>> FRAC_W;
    end else begin
      q = -((-acc + HALF) >>> FRAC_W);
    end
    return q[POS_W-1:0];
  endfunction

  task automatic advance_servo(input logic f, input logic [POS_W-1:0] pos,
                               input logic [EL_W-1:0] el);
    drive_t r;
    longint rate, elv, step, tgt, err, x, u, idx, mag;
    r.direction = dir_model;
    r.pwm_level = '0;
    r.at_target = 1'b0;
    r.near_target = 1'b0;
    if (f) begin
      mv_acc = 0;
      sp_acc = 0;
      sp_model = '0;
    end else begin
      rate = longint'(cfg_rate);
      elv = longint'(el);
      if (!cfg_mode) begin
        tgt = longint'(cfg_target);
        step = (rate < 0 ? -rate : rate) * elv;
        if (cfg_reverse) begin
          tgt = -tgt;
          if (tgt > MAXPOS) tgt = MAXPOS;
        end
        if (sp_model < tgt) begin
          mv_acc = wrap_acc(mv_acc + step);
          sp_model = round_setpoint(mv_acc);
        end else if (sp_model > tgt) begin
          mv_acc = wrap_acc(mv_acc - step);
          sp_model = round_setpoint(mv_acc);
        end else begin
          r.at_target = 1'b1;
        end
      end else begin
        if (cfg_reverse) rate = -rate;
        sp_acc = wrap_acc(sp_acc + rate * elv);
        sp_model = round_setpoint(sp_acc);
      end
      err = longint'($signed(pos)) - longint'(sp_model);
      r.near_target = (err <= NEAR_LIMIT);
      x = longint'(cfg_gain) * (1 + err);
      mag = 0;
      if (x != 0) begin
        u = (x < 0) ? -x : x;
        idx = (u * TBL_DEPTH) >> (FRAC_W + 4);
        if (idx >= TBL_DEPTH) begin
          mag = longint'(cfg_max);
        end else begin
          mag = (longint'(cfg_max) * tanh_q16[idx]) >> 16;
        end
        if (mag != 0) dir_model = (x > 0);
      end
      r.direction = dir_model;
      r.pwm_level = mag[PWM_W-1:0];
    end
    drive_expected.push_back(r);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // input side: transfer detection and prediction
  always @(posedge clk) begin
    if (rst) begin
      in_done <= 1'b0;
    end else begin
      in_done <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        advance_servo(func, position, elapsed_us);
        ticks_accepted++;
      end
    end
  end

  // output side: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid && out_ready) begin
      if (drive_expected.size() == 0) begin
        mismatches++;
        $error("output transfer with no prediction pending");
      end else begin
        want = drive_expected.pop_front();
        check_field("direction", 32'(want.direction), 32'(direction));
        check_field("pwm_level", 32'(want.pwm_level), 32'(pwm_level));
        check_field("at_target", 32'(want.at_target), 32'(at_target));
        check_field("near_target", 32'(want.near_target), 32'(near_target));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[position_servo_sigmoid_drive_unit] ERROR");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_done) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() == 0 ||
                   (tick_queue[0].drain && drive_expected.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        tx_req = tick_queue.pop_front();
        func <= tx_req.func;
        position <= tx_req.rel ? POS_W'(sp_model + tx_req.offset) : tx_req.position;
        elapsed_us <= tx_req.elapsed;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(99) < tx_idle_pct) tx_gap = $urandom_range(1, 17);
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_hold_req) begin
        rx_stall = 400;
        rx_hold_req = 1'b0;
      end else if (rx_stall == 0 && !calm && $urandom_range(99) < rx_idle_pct) begin
        rx_stall = $urandom_range(1, 17);
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_tick(input logic f, input logic rel, input int offset,
                          input logic [POS_W-1:0] pos, input logic [EL_W-1:0] el,
                          input logic drain);
    tick_req_t t;
    t.func = f;
    t.rel = rel;
    t.offset = offset;
    t.position = pos;
    t.elapsed = el;
    t.drain = drain;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  task automatic wait_drained();
    while (ticks_accepted != ticks_queued || drive_expected.size() != 0) @(negedge clk);
  endtask

  task automatic reg_write(input logic [RIDX_W-1:0] ridx, input logic [PDATA_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ridx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (ridx)
      REG_TARGET:  cfg_target = val[POS_W-1:0];
      REG_RATE:    cfg_rate = val[RATE_W-1:0];
      REG_MODE:    cfg_mode = val[0];
      REG_MAXDRV:  cfg_max = val[PWM_W-1:0];
      REG_REVERSE: cfg_reverse = val[0];
      REG_GAIN:    cfg_gain = val[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [POS_W-1:0] tgt, input logic [RATE_W-1:0] rate,
                             input logic mode, input logic [PWM_W-1:0] maxd,
                             input logic rev, input logic [GAIN_W-1:0] gain);
    reg_write(REG_TARGET, PDATA_W'(tgt));
    reg_write(REG_RATE, PDATA_W'(rate));
    reg_write(REG_MODE, PDATA_W'(mode));
    reg_write(REG_MAXDRV, PDATA_W'(maxd));
    reg_write(REG_REVERSE, PDATA_W'(rev));
    reg_write(REG_GAIN, PDATA_W'(gain));
  endtask

  function automatic logic [POS_W-1:0] rnd_s24();
    case ($urandom_range(7))
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'h000000;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rnd_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2, 3: return GAIN_W'($urandom_range(1, 16));
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  initial begin
    int kind, r, el_lim, off;
    logic [RATE_W-1:0] rate;
    logic [POS_W-1:0] tgt;
    logic [PWM_W-1:0] maxd;
    build_tanh_q16();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: zero error, x = 0, far ends of the table, near limit
    add_tick(0, 0, 0, 24'h000000, 16'h0000, 0);
    add_tick(0, 0, 0, 24'hffffff, 16'h0000, 0);
    add_tick(0, 0, 0, 24'h7fffff, 16'hffff, 0);
    add_tick(0, 0, 0, 24'h800000, 16'h0000, 0);
    add_tick(0, 0, 0, 24'd250, 16'h0000, 0);
    add_tick(0, 0, 0, 24'd251, 16'h0000, 0);
    add_tick(1, 0, 0, 24'h7fffff, 16'hffff, 0);
    wait_drained();

    // move with overshoot toward a nearby target
    reg_write(REG_TARGET, PDATA_W'(1000));
    for (int i = 0; i < 4; i++) add_tick(0, 1, 0, '0, 16'hffff, 0);
    add_tick(0, 1, 300, '0, 16'h8000, 0);
    add_tick(1, 0, 0, 24'h000001, 16'h0001, 0);
    wait_drained();

    // mirrored most negative target, largest step, accumulator wrap
    load_config(24'h800000, 24'h800000, 1'b0, 8'hff, 1'b1, 16'hffff);
    for (int i = 0; i < 3; i++) add_tick(0, 1, 0, '0, 16'hffff, 0);
    add_tick(0, 1, 5, '0, 16'h0000, 0);
    add_tick(0, 0, 0, 24'h000000, 16'h0001, 0);
    wait_drained();

    // spin at the largest rate, zero gain, then mirrored
    load_config(24'h000000, 24'h7fffff, 1'b1, 8'd128, 1'b0, 16'h0000);
    add_tick(0, 0, 0, 24'h123456, 16'hffff, 0);
    add_tick(0, 0, 0, 24'hedcba9, 16'hffff, 0);
    add_tick(1, 0, 0, 24'h000000, 16'h0000, 0);
    wait_drained();
    reg_write(REG_REVERSE, PDATA_W'(1));
    reg_write(REG_GAIN, PDATA_W'(1));
    add_tick(0, 1, 3, '0, 16'd100, 0);
    add_tick(0, 1, -3, '0, 16'd100, 0);

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      kind = (p == PHASES - 1) ? 0 : p % 3;
      calm = (p == PHASES - 1);
      tx_idle_pct = (p % 4 == 3) ? 0 : 10 * $urandom_range(0, 3);
      rx_idle_pct = (p % 4 == 2) ? 0 : 10 * $urandom_range(0, 3);
      case ($urandom_range(3))
        0: maxd = '0;
        1: maxd = '1;
        default: maxd = PWM_W'($urandom);
      endcase
      if (kind == 0) begin
        // fine move: whole-count steps so the setpoint lands on the target
        rate = RATE_W'($urandom_range(1, 2) << FRAC_W);
        if ($urandom_range(1)) rate = -rate;
        tgt = POS_W'(int'($urandom_range(0, 600)) - 300);
        el_lim = 3;
        load_config(tgt, rate, 1'b0, maxd, 1'($urandom), rnd_gain());
      end else if (kind == 1) begin
        el_lim = 65535;
        load_config(rnd_s24(), rnd_s24(), 1'b0, maxd, 1'($urandom), rnd_gain());
      end else begin
        rate = ($urandom_range(3) == 0) ? rnd_s24()
                                        : RATE_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        el_lim = 65535;
        load_config(rnd_s24(), rate, 1'b1, maxd, 1'($urandom), rnd_gain());
      end
      for (int i = 0; i < PHASE_TICKS; i++) begin
        r = $urandom_range(99);
        if (r < 5) begin
          add_tick(1, 0, 0, POS_W'($urandom), EL_W'($urandom), 0);
        end else if (r < 22) begin
          add_tick(0, 0, 0, POS_W'($urandom), EL_W'($urandom_range(0, el_lim)), 0);
        end else if (r < 26) begin
          add_tick(0, 0, 0, rnd_s24(), EL_W'($urandom_range(0, el_lim)), 0);
        end else begin
          off = (r < 60) ? int'($urandom_range(0, 40)) - 20
                         : int'($urandom_range(0, 2000)) - 1000;
          add_tick(0, 1, off, '0, EL_W'($urandom_range(0, el_lim)),
                   $urandom_range(99) == 0);
        end
      end
      if (p == 1) rx_hold_req = 1'b1;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && drive_expected.size() == 0) begin
      $display("[position_servo_sigmoid_drive_unit] OK");
    end else begin
      $display("[position_servo_sigmoid_drive_unit] ERROR");
    end
    $finish;
  end

endmodule
